>>> rtl/core/itad_pkg.sv
`default_nettype none

package itad_pkg;

  // Depth of the queue between parser and output stage
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [6:0] fg_colour;
    logic       fg_is_default;
    logic [6:0] bg_colour;
    logic       bg_is_default;
    logic       bold_on;
    logic       underline_on;
    logic       italic_on;
  } attr_t;

  // One parsed byte: one or two output characters sharing one attribute set
  typedef struct packed {
    logic [7:0] char0;
    logic [7:0] char1;
    logic       two;
    attr_t      attrs;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

>>> rtl/core/itad_front.sv
`default_nettype none

module itad_front
  import itad_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [6:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       cmd,
  input  wire logic [7:0] char_code,
  input  q_status_t       q_status,
  output logic            push,
  output bundle_t         push_data
);

  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_UC_C  = 8'h43;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // colours default, attributes clear
  localparam attr_t ATTR_RESET = '{
    fg_colour:     7'd0,
    fg_is_default: 1'b1,
    bg_colour:     7'd0,
    bg_is_default: 1'b1,
    bold_on:       1'b0,
    underline_on:  1'b0,
    italic_on:     1'b0
  };

  typedef enum logic [2:0] {
    P_IDLE,
    P_MARK,
    P_FG1,
    P_FG2,
    P_COMMA,
    P_BG1
  } phase_t;

  phase_t     phase, phase_next;
  logic       tilde, tilde_next;
  logic [3:0] num, num_next;
  attr_t      attrs, attrs_next;
  logic [6:0] max_colour;

  logic [1:0] n_res;
  logic [7:0] ch0, ch1;
  logic       do_idle;
  logic       is_digit, is_tilde, is_mark;
  logic [7:0] dig;
  logic [6:0] two_digit;
  logic       accept;

  assign in_ready  = ~q_status.full;
  assign accept    = in_valid & in_ready;
  assign dig       = char_code - CH_ZERO;
  assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_tilde  = (char_code == CH_TILDE);
  assign is_mark   = is_tilde || (char_code == CH_ETX);
  assign two_digit = 7'(7'(num) * 7'd10) + 7'(dig[3:0]);

  always_comb begin
    phase_next = phase;
    tilde_next = tilde;
    num_next   = num;
    attrs_next = attrs;
    n_res      = 2'd0;
    ch0        = char_code;
    ch1        = char_code;
    do_idle    = 1'b0;
    if (cmd) begin
      // end of string: flush whatever is pending
      unique case (phase)
        P_MARK: begin
          if (tilde) begin
            n_res = 2'd1;
            ch0   = CH_TILDE;
          end else begin
            attrs_next.fg_is_default = 1'b1;
            attrs_next.bg_is_default = 1'b1;
          end
        end
        P_FG1: begin
          if (7'(num) <= max_colour) begin
            attrs_next.fg_colour     = 7'(num);
            attrs_next.fg_is_default = 1'b0;
          end
          attrs_next.bg_is_default = 1'b1;
        end
        P_BG1: begin
          if (7'(num) <= max_colour) begin
            attrs_next.bg_colour     = 7'(num);
            attrs_next.bg_is_default = 1'b0;
          end
        end
        default: begin
        end
      endcase
      phase_next = P_IDLE;
    end else begin
      unique case (phase)
        P_MARK: begin
          phase_next = P_IDLE;
          if (is_digit) begin
            num_next   = dig[3:0];
            phase_next = P_FG1;
          end else begin
            unique case (char_code)
              CH_LC_C: begin
                attrs_next.fg_is_default = 1'b1;
                attrs_next.bg_is_default = 1'b1;
              end
              CH_UC_C: begin
                attrs_next.fg_is_default = 1'b1;
                attrs_next.bg_is_default = 1'b1;
                attrs_next.bold_on       = 1'b0;
                attrs_next.underline_on  = 1'b0;
                attrs_next.italic_on     = 1'b0;
              end
              CH_B:     attrs_next.bold_on      = ~attrs.bold_on;
              CH_U:     attrs_next.underline_on = ~attrs.underline_on;
              CH_I:     attrs_next.italic_on    = ~attrs.italic_on;
              CH_TILDE: begin
                n_res = 2'd1;
                ch0   = CH_TILDE;
              end
              default: begin
                // unknown code: '~' marker echoes itself, 0x03 drops colours
                if (tilde) begin
                  n_res = 2'd1;
                  ch0   = CH_TILDE;
                end else begin
                  attrs_next.fg_is_default = 1'b1;
                  attrs_next.bg_is_default = 1'b1;
                end
                do_idle = 1'b1;
              end
            endcase
          end
        end
        P_FG1: begin
          attrs_next.bg_is_default = 1'b1;
          if (is_digit) begin
            if (two_digit <= max_colour) begin
              attrs_next.fg_colour     = two_digit;
              attrs_next.fg_is_default = 1'b0;
            end
            phase_next = P_FG2;
          end else begin
            if (7'(num) <= max_colour) begin
              attrs_next.fg_colour     = 7'(num);
              attrs_next.fg_is_default = 1'b0;
            end
            if (char_code == CH_COMMA) begin
              phase_next = P_COMMA;
            end else begin
              do_idle = 1'b1;
            end
          end
        end
        P_FG2: begin
          if (char_code == CH_COMMA) begin
            phase_next = P_COMMA;
          end else begin
            do_idle = 1'b1;
          end
        end
        P_COMMA: begin
          if (is_digit) begin
            num_next   = dig[3:0];
            phase_next = P_BG1;
          end else begin
            do_idle = 1'b1;
          end
        end
        P_BG1: begin
          if (is_digit) begin
            if (two_digit <= max_colour) begin
              attrs_next.bg_colour     = two_digit;
              attrs_next.bg_is_default = 1'b0;
            end
            phase_next = P_IDLE;
          end else begin
            if (7'(num) <= max_colour) begin
              attrs_next.bg_colour     = 7'(num);
              attrs_next.bg_is_default = 1'b0;
            end
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase
      // plain byte handling with no marker pending
      if (do_idle) begin
        if (is_mark) begin
          phase_next = P_MARK;
          tilde_next = is_tilde;
        end else begin
          phase_next = P_IDLE;
          if (n_res == 2'd1) begin
            ch1   = char_code;
            n_res = 2'd2;
          end else begin
            ch0   = char_code;
            n_res = 2'd1;
          end
        end
      end
    end
  end

  // emitted bytes always carry the updated attributes
  assign push            = accept && (n_res != 2'd0);
  assign push_data.char0 = ch0;
  assign push_data.char1 = ch1;
  assign push_data.two   = (n_res == 2'd2);
  assign push_data.attrs = attrs_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                    <= P_IDLE;
      tilde                    <= 1'b0;
      num                      <= 4'd0;
      attrs                    <= ATTR_RESET;
      max_colour               <= 7'd15;
    end else begin
      if (cfg_wr_en) begin
        max_colour <= cfg_wr_data;
      end
      if (accept) begin
        phase <= phase_next;
        tilde <= tilde_next;
        num   <= num_next;
        attrs <= attrs_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/itad_queue.sv
`default_nettype none

module itad_queue
  import itad_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  bundle_t   push_data,
  input  wire logic pop,
  output q_status_t q_status,
  output bundle_t   head
);

  bundle_t           entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_status.full  = (count == QCNT_W'(QDEPTH));
  assign q_status.empty = (count == '0);
  assign head           = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/itad_back.sv
`default_nettype none

module itad_back
  import itad_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  q_status_t q_status,
  input  bundle_t   head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [7:0] out_char,
  output attr_t     out_attrs,
  output logic      last_of_run
);

  // set while the second character of a two-character entry is shown
  logic half;
  logic xfer;

  assign out_valid   = ~q_status.empty;
  assign xfer        = out_valid & out_ready;
  assign last_of_run = ~head.two | half;
  assign pop         = xfer & last_of_run;
  assign out_char    = half ? head.char1 : head.char0;
  assign out_attrs   = head.attrs;

  always_ff @(posedge clk) begin
    if (rst) begin
      half <= 1'b0;
    end else if (xfer) begin
      half <= head.two & ~half;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/irc_text_attribute_decoder.sv
// Throughput: one input byte per cycle while the queue is not full; the output
// stage sends one result per cycle while out_ready is high, so a byte that
// yields two results (echoed '~' plus a byte) needs two output transfers.
// A four-entry queue between parser and output stage absorbs those bursts.
// Reset (rst, synchronous): parser idle, colours default, attributes clear,
// max_colour back to 15, queue empty.
`default_nettype none

module irc_text_attribute_decoder
  import itad_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration: max_colour
  input  wire logic       cfg_wr_en,
  input  wire logic [6:0] cfg_wr_data,
  // input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       cmd,
  input  wire logic [7:0] char_code,
  // output channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic [6:0]      fg_colour,
  output logic            fg_is_default,
  output logic [6:0]      bg_colour,
  output logic            bg_is_default,
  output logic            bold_on,
  output logic            underline_on,
  output logic            italic_on,
  output logic            last_of_run
);

  q_status_t q_status;
  logic      push;
  bundle_t   push_data;
  logic      pop;
  bundle_t   head;
  attr_t     out_attrs;

  // Front: parse state machine, one byte per transfer; packs the result(s)
  // of a byte into one queue entry. Stalls only when the queue is full.
  itad_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .char_code   (char_code),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  // Queue between the two halves
  itad_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_status  (q_status),
    .head      (head)
  );

  // Back: unpacks an entry into one or two output transfers
  itad_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .out_attrs   (out_attrs),
    .last_of_run (last_of_run)
  );

  assign fg_colour     = out_attrs.fg_colour;
  assign fg_is_default = out_attrs.fg_is_default;
  assign bg_colour     = out_attrs.bg_colour;
  assign bg_is_default = out_attrs.bg_is_default;
  assign bold_on       = out_attrs.bold_on;
  assign underline_on  = out_attrs.underline_on;
  assign italic_on     = out_attrs.italic_on;

endmodule

`default_nettype wire
